>>> sv/qvr_pkg.sv
package qvr_pkg;

  // width of every vector, quaternion and result component
  localparam int COMP_W = 32;

  // width of one exact first-pass product and of an exact first-pass sum
  localparam int PROD1_W = 2 * COMP_W;
  localparam int SUM1_W = PROD1_W + 3;

  // low slice of t handled by the unsigned partial product
  localparam int LO_BITS = 26;

  // register stages from accepted input to result register
  localparam int STAGES = 5;

  localparam logic signed [COMP_W-1:0] ROT_MAX = {1'b0, {(COMP_W - 1){1'b1}}};
  localparam logic signed [COMP_W-1:0] ROT_MIN = {1'b1, {(COMP_W - 1){1'b0}}};

  // quaternion parts are indexed w, i, j, k
  localparam logic [1:0] QW = 2'd0;
  localparam logic [1:0] QI = 2'd1;
  localparam logic [1:0] QJ = 2'd2;
  localparam logic [1:0] QK = 2'd3;

  // first pass t = v * q: term n uses vector part n % 3 and quaternion part below
  localparam logic [1:0] Q_SEL1 [12] = '{
    QW, QK, QJ,
    QK, QW, QI,
    QJ, QI, QW,
    QI, QJ, QK
  };
  localparam logic [11:0] NEG1 = 12'b1110_1000_1100;

  // second pass conj(q) * t: term n uses quaternion part n % 4 and the t below
  localparam logic [1:0] T_SEL2 [12] = '{
    2'd0, 2'd3, 2'd2, 2'd1,
    2'd1, 2'd2, 2'd3, 2'd0,
    2'd2, 2'd1, 2'd0, 2'd3
  };
  localparam logic [11:0] NEG2 = 12'b1010_1100_0110;

  typedef struct packed {
    logic signed [COMP_W-1:0] vec_x;
    logic signed [COMP_W-1:0] vec_y;
    logic signed [COMP_W-1:0] vec_z;
    logic signed [COMP_W-1:0] quat_i;
    logic signed [COMP_W-1:0] quat_j;
    logic signed [COMP_W-1:0] quat_k;
    logic signed [COMP_W-1:0] quat_w;
  } item_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] rot_x;
    logic signed [COMP_W-1:0] rot_y;
    logic signed [COMP_W-1:0] rot_z;
    logic                     overflow;
  } result_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

>>> sv/quaternion_vector_rotate.sv
// rotates a 3-vector by a quaternion, computing conj(q) * (x, y, z, 0) * q in
// fixed point and returning the imaginary parts. vector and result components
// are signed 32-bit values (Q15.16 as delivered), quaternion parts are signed
// 32-bit values with QUAT_FRAC_BITS fraction bits. the result is a true
// rotation only for a unit quaternion; otherwise it comes out scaled by |q|^2.
// each pass keeps its sums of products exact and rounds to nearest (ties
// toward plus infinity); the final components saturate to 32 bits and the
// overflow flag marks a transaction in which any component saturated.
// throughput is one transaction per clock while the result side accepts. the
// stages from input accept to result valid are first-pass products, first-pass
// sums, split second-pass partial products, product recombine, then sum, round
// and saturate into the result register. the depth is set by the second-pass
// multiply, where t is wider than one multiplier and is cut into two
// partial products. a stall on the result side holds the pipeline and fills
// any bubbles behind it, so input ready drops only when every stage is full.
module quaternion_vector_rotate #(
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  qvr_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output qvr_pkg::result_t  result
);

  localparam int NS = qvr_pkg::STAGES;

  // one valid bit per register stage, travels with the data
  logic [NS-1:0]      stage_valid;
  logic [NS-1:0]      adv;
  qvr_pkg::stage_en_t en;

  // a stage may load when it is empty or its contents move on this cycle
  always_comb begin
    adv[NS-1] = !stage_valid[NS-1] || result_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !stage_valid[k] || adv[k+1];
    end
  end

  assign en.s1 = adv[0];
  assign en.s2 = adv[1];
  assign en.s3 = adv[2];
  assign en.s4 = adv[3];
  assign en.s5 = adv[4];

  assign item_ready   = adv[0];
  assign result_valid = stage_valid[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      // first stage takes the input transaction, later stages the one ahead
      if (adv[0]) begin
        stage_valid[0] <= item_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  // arithmetic stages; payload registers load on the same enables
  qvr_datapath #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_datapath (
    .clk    (clk),
    .en     (en),
    .item   (item),
    .result (result)
  );

endmodule

>>> sv/qvr_datapath.sv
module qvr_datapath #(
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic                clk,
  input  qvr_pkg::stage_en_t  en,
  input  qvr_pkg::item_t      item,
  output qvr_pkg::result_t    result
);

  localparam int CW   = qvr_pkg::COMP_W;
  localparam int P1W  = qvr_pkg::PROD1_W;
  localparam int S1W  = qvr_pkg::SUM1_W;
  localparam int LO   = qvr_pkg::LO_BITS;
  localparam int TW   = S1W - QUAT_FRAC_BITS;
  localparam int HW   = TW - LO;
  localparam int HPW  = CW + HW;
  localparam int LPW  = CW + LO + 1;
  localparam int PW   = CW + TW;
  localparam int S2W  = PW + 3;
  localparam int SHW  = S2W - QUAT_FRAC_BITS;

  localparam logic signed [S1W-1:0] HALF1 = S1W'(1) << (QUAT_FRAC_BITS - 1);
  localparam logic signed [S2W-1:0] HALF2 = S2W'(1) << (QUAT_FRAC_BITS - 1);

  logic signed [CW-1:0]  vec_in [3];
  logic signed [CW-1:0]  quat_in [4];

  // stage 1: exact first-pass products
  logic signed [P1W-1:0] prod1 [12];
  logic signed [CW-1:0]  quat1 [4];

  // stage 2: rounded t
  logic signed [S1W-1:0] acc1 [4];
  logic signed [S1W-1:0] sh1 [4];
  logic signed [TW-1:0]  t_next [4];
  logic signed [TW-1:0]  t2 [4];
  logic signed [CW-1:0]  quat2 [4];

  // stage 3: split partial products
  logic signed [HPW-1:0] pp_hi [12];
  logic signed [LPW-1:0] pp_lo [12];

  // stage 4: recombined products
  logic signed [PW-1:0]  prod2 [12];

  // stage 5: sums, rounding, saturation
  logic signed [S2W-1:0] acc2 [3];
  logic signed [S2W-1:0] sh2 [3];
  logic signed [CW-1:0]  rot_next [3];
  logic [2:0]            ovf_next;
  qvr_pkg::result_t      res;

  assign vec_in[0]  = item.vec_x;
  assign vec_in[1]  = item.vec_y;
  assign vec_in[2]  = item.vec_z;
  assign quat_in[qvr_pkg::QW] = item.quat_w;
  assign quat_in[qvr_pkg::QI] = item.quat_i;
  assign quat_in[qvr_pkg::QJ] = item.quat_j;
  assign quat_in[qvr_pkg::QK] = item.quat_k;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int n = 0; n < 12; n++) begin
        prod1[n] <= P1W'(vec_in[2'(n % 3)]) * P1W'(quat_in[qvr_pkg::Q_SEL1[n]]);
      end
      quat1 <= quat_in;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc1[k] = HALF1;
      for (int m = 0; m < 3; m++) begin
        if (qvr_pkg::NEG1[3 * k + m]) begin
          acc1[k] = acc1[k] - S1W'(prod1[3 * k + m]);
        end else begin
          acc1[k] = acc1[k] + S1W'(prod1[3 * k + m]);
        end
      end
      sh1[k]    = acc1[k] >>> QUAT_FRAC_BITS;
      t_next[k] = sh1[k][TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      t2    <= t_next;
      quat2 <= quat1;
    end
  end

  // t is wider than a multiplier port: signed high slice and unsigned low slice
  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int n = 0; n < 12; n++) begin
        pp_hi[n] <= HPW'(quat2[2'(n % 4)]) *
                    HPW'($signed(t2[qvr_pkg::T_SEL2[n]][TW-1:LO]));
        pp_lo[n] <= LPW'(quat2[2'(n % 4)]) *
                    LPW'($signed({1'b0, t2[qvr_pkg::T_SEL2[n]][LO-1:0]}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      for (int n = 0; n < 12; n++) begin
        prod2[n] <= (PW'(pp_hi[n]) <<< LO) + PW'(pp_lo[n]);
      end
    end
  end

  always_comb begin
    for (int o = 0; o < 3; o++) begin
      acc2[o] = HALF2;
      for (int m = 0; m < 4; m++) begin
        if (qvr_pkg::NEG2[4 * o + m]) begin
          acc2[o] = acc2[o] - S2W'(prod2[4 * o + m]);
        end else begin
          acc2[o] = acc2[o] + S2W'(prod2[4 * o + m]);
        end
      end
      sh2[o] = acc2[o] >>> QUAT_FRAC_BITS;
      // fits when every bit from the result sign upward agrees
      if ((&sh2[o][SHW-1:CW-1]) || !(|sh2[o][SHW-1:CW-1])) begin
        rot_next[o] = sh2[o][CW-1:0];
        ovf_next[o] = 1'b0;
      end else begin
        rot_next[o] = sh2[o][SHW-1] ? qvr_pkg::ROT_MIN : qvr_pkg::ROT_MAX;
        ovf_next[o] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      res.rot_x    <= rot_next[0];
      res.rot_y    <= rot_next[1];
      res.rot_z    <= rot_next[2];
      res.overflow <= |ovf_next;
    end
  end

  assign result = res;

endmodule

>>> sv/qvr_checker.sv
module qvr_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input qvr_pkg::result_t result
);

  // a result waiting for the sink keeps its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // a draining output frees every stage, so the input side is open
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    result_ready |-> item_ready)
    else $error("input blocked while output drains");

  // overflow only with some component at a rail
  a_ovf_rail: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.overflow |->
      result.rot_x == qvr_pkg::ROT_MAX || result.rot_x == qvr_pkg::ROT_MIN ||
      result.rot_y == qvr_pkg::ROT_MAX || result.rot_y == qvr_pkg::ROT_MIN ||
      result.rot_z == qvr_pkg::ROT_MAX || result.rot_z == qvr_pkg::ROT_MIN)
    else $error("overflow flagged without a saturated component");

  // an idle input with nothing in flight keeps the output idle
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !result_valid && !item_valid && item_ready && $past(!item_valid) &&
    $past(!item_valid, 2) && $past(!item_valid, 3) && $past(!item_valid, 4) &&
    $past(!rst, 5) |=> !result_valid)
    else $error("result without a transaction");

endmodule

bind quaternion_vector_rotate qvr_checker u_checker (.*);

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QFB = 30;
  localparam int ACC_W = 128;

  // handy fixed-point values: 1.0 in the vector format and in the quaternion format
  localparam logic signed [31:0] V_ONE = 32'sd65536;
  localparam logic signed [31:0] Q_ONE = 32'sd1073741824;
  localparam logic signed [31:0] Q_HALF = 32'sd536870912;
  localparam logic signed [31:0] Q_COS45 = 32'sd759250125;

  localparam logic signed [31:0] R_MAX = qvr_pkg::ROT_MAX;
  localparam logic signed [31:0] R_MIN = qvr_pkg::ROT_MIN;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = 128'sd1 <<< (QFB - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = R_MAX;
  localparam logic signed [ACC_W-1:0] SAT_LO = R_MIN;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_ready;
  qvr_pkg::item_t   item;
  logic             result_valid;
  logic             result_ready;
  qvr_pkg::result_t result;

  qvr_pkg::result_t expected_rotations[$];
  int      fail_count = 0;
  bit      sender_idles = 0;
  bit      receiver_idles = 0;
  int      hold_left = 0;

  quaternion_vector_rotate #(
    .QUAT_FRAC_BITS(QFB)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  // round to nearest, ties toward plus infinity, at the quaternion scale
  function automatic logic signed [ACC_W-1:0] round_q(logic signed [ACC_W-1:0] a);
    return (a + ROUND_HALF) >>> QFB;
  endfunction

  // conj(q) * (x, y, z, 0) * q with exact sums, rounding per pass, saturated output
  function automatic qvr_pkg::result_t predict_rotation(qvr_pkg::item_t it);
    logic signed [ACC_W-1:0] vx, vy, vz, qi, qj, qk, qw;
    logic signed [ACC_W-1:0] t1, t2, t3, t4;
    logic signed [ACC_W-1:0] sum [3];
    logic signed [31:0]      comp [3];
    logic                    ovf;
    qvr_pkg::result_t        r;
    vx = $signed(it.vec_x);
    vy = $signed(it.vec_y);
    vz = $signed(it.vec_z);
    qi = $signed(it.quat_i);
    qj = $signed(it.quat_j);
    qk = $signed(it.quat_k);
    qw = $signed(it.quat_w);
    t1 = round_q(vx * qw + vy * qk - vz * qj);
    t2 = round_q(-vx * qk + vy * qw + vz * qi);
    t3 = round_q(vx * qj - vy * qi + vz * qw);
    t4 = round_q(-vx * qi - vy * qj - vz * qk);
    sum[0] = round_q(qw * t1 - qi * t4 - qj * t3 + qk * t2);
    sum[1] = round_q(qw * t2 + qi * t3 - qj * t4 - qk * t1);
    sum[2] = round_q(qw * t3 - qi * t2 + qj * t1 - qk * t4);
    ovf = 1'b0;
    for (int n = 0; n < 3; n++) begin
      if (sum[n] > SAT_HI) begin
        comp[n] = R_MAX;
        ovf = 1'b1;
      end else if (sum[n] < SAT_LO) begin
        comp[n] = R_MIN;
        ovf = 1'b1;
      end else begin
        comp[n] = sum[n][31:0];
      end
    end
    r.rot_x = comp[0];
    r.rot_y = comp[1];
    r.rot_z = comp[2];
    r.overflow = ovf;
    return r;
  endfunction

  function automatic qvr_pkg::item_t make_item(logic signed [31:0] x, logic signed [31:0] y,
                                               logic signed [31:0] z, logic signed [31:0] i,
                                               logic signed [31:0] j, logic signed [31:0] k,
                                               logic signed [31:0] w);
    qvr_pkg::item_t it;
    it.vec_x = x;
    it.vec_y = y;
    it.vec_z = z;
    it.quat_i = i;
    it.quat_j = j;
    it.quat_k = k;
    it.quat_w = w;
    return it;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // vector component: extremes, small magnitudes or full random
  function automatic logic signed [31:0] random_component();
    case ($urandom_range(0, 9))
      0: return R_MAX;
      1: return R_MIN;
      2, 3, 4: return $signed($urandom) >>> $urandom_range(4, 24);
      default: return $signed($urandom);
    endcase
  endfunction

  // random quaternion of length scale, random vector
  function automatic qvr_pkg::item_t random_rotation_item(real scale);
    real            c [4];
    real            norm;
    qvr_pkg::item_t it;
    norm = 0.0;
    for (int n = 0; n < 4; n++) begin
      c[n] = $itor($signed($urandom)) / 2147483648.0;
      norm += c[n] * c[n];
    end
    if (norm < 1.0e-6) begin
      c = '{0.0, 0.0, 0.0, 1.0};
      norm = 1.0;
    end
    norm = $sqrt(norm);
    it.quat_i = $rtoi(c[0] / norm * scale * 1073741824.0);
    it.quat_j = $rtoi(c[1] / norm * scale * 1073741824.0);
    it.quat_k = $rtoi(c[2] / norm * scale * 1073741824.0);
    it.quat_w = $rtoi(c[3] / norm * scale * 1073741824.0);
    it.vec_x = random_component();
    it.vec_y = random_component();
    it.vec_z = random_component();
    return it;
  endfunction

  // one transaction on the input side; valid stays up after acceptance
  task automatic send_item(input qvr_pkg::item_t it);
    int gap;
    gap = 0;
    if (sender_idles && $urandom_range(0, 3) == 0) gap = idle_length();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    expected_rotations.push_back(predict_rotation(it));
  endtask

  // stop offering and let the pipeline empty out
  task automatic wait_for_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_rotations.size() != 0);
    repeat (qvr_pkg::STAGES + 2) @(posedge clk);
  endtask

  task automatic check_rotation(input qvr_pkg::result_t got);
    qvr_pkg::result_t exp;
    if (expected_rotations.size() == 0) begin
      $display("%0t ns: unexpected result x=%0d y=%0d z=%0d ovf=%0b", $time,
               got.rot_x, got.rot_y, got.rot_z, got.overflow);
      fail_count++;
    end else begin
      exp = expected_rotations.pop_front();
      if (got.rot_x !== exp.rot_x) begin
        $display("%0t ns: rot_x expected %0d got %0d", $time, exp.rot_x, got.rot_x);
        fail_count++;
      end
      if (got.rot_y !== exp.rot_y) begin
        $display("%0t ns: rot_y expected %0d got %0d", $time, exp.rot_y, got.rot_y);
        fail_count++;
      end
      if (got.rot_z !== exp.rot_z) begin
        $display("%0t ns: rot_z expected %0d got %0d", $time, exp.rot_z, got.rot_z);
        fail_count++;
      end
      if (got.overflow !== exp.overflow) begin
        $display("%0t ns: overflow expected %0b got %0b", $time, exp.overflow,
                 got.overflow);
        fail_count++;
      end
    end
  endtask

  // result side: checks every transaction and drives ready with random stalls
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) check_rotation(result);
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
        stall_left = idle_length() - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // identity, axis rotations, ties, saturation both ways, full-scale negation
  task automatic test_directed_cases();
    send_item(make_item(0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(R_MAX, R_MIN, 1, 0, 0, 0, Q_ONE));
    send_item(make_item(-1, V_ONE, -V_ONE, 0, 0, 0, Q_ONE));
    send_item(make_item(12345, -6789, 32'sh7fff0000, 0, 0, 0, -Q_ONE));
    send_item(make_item(0, V_ONE, 0, Q_COS45, 0, 0, Q_COS45));
    send_item(make_item(V_ONE, 0, 0, 0, Q_COS45, 0, Q_COS45));
    send_item(make_item(V_ONE, V_ONE, V_ONE, 0, 0, Q_COS45, Q_COS45));
    send_item(make_item(3 * V_ONE, -V_ONE, 7, Q_ONE, 0, 0, 0));
    send_item(make_item(3 * V_ONE, -V_ONE, 7, 0, Q_ONE, 0, 0));
    send_item(make_item(3 * V_ONE, -V_ONE, 7, 0, 0, Q_ONE, 0));
    send_item(make_item(V_ONE, 2 * V_ONE, 3 * V_ONE, Q_HALF, Q_HALF, Q_HALF, Q_HALF));
    // full-scale negative everywhere
    send_item(make_item(R_MIN, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN, R_MIN));
    send_item(make_item(R_MAX, R_MAX, R_MAX, R_MIN, R_MIN, R_MIN, R_MIN));
    send_item(make_item(1, -1, 1, R_MAX, R_MAX, R_MAX, R_MAX));
    // |q| near 2 scales by about 4: positive then negative saturation
    send_item(make_item(32'sh40000000, 0, 0, 0, 0, 0, R_MAX));
    send_item(make_item(32'shc0000000, 0, 0, 0, 0, 0, R_MAX));
    send_item(make_item(R_MIN, 0, R_MAX, 0, 0, 0, R_MIN));
    // alternating bit patterns on every field
    send_item(make_item(32'shaaaaaaaa, 32'shaaaaaaaa, 32'shaaaaaaaa, 32'shaaaaaaaa,
                        32'shaaaaaaaa, 32'shaaaaaaaa, 32'shaaaaaaaa));
    send_item(make_item(32'sh55555555, 32'sh55555555, 32'sh55555555, 32'sh55555555,
                        32'sh55555555, 32'sh55555555, 32'sh55555555));
    // exact halves: rounding ties go toward plus infinity
    send_item(make_item(1, -1, 0, 0, 0, 0, Q_HALF));
    send_item(make_item(3, -3, 1, 0, 0, 0, Q_HALF));
    send_item(make_item(R_MAX, R_MAX, R_MIN, 1, -1, 1, -1));
  endtask

  task automatic test_unit_rotations(input int count);
    repeat (count) send_item(random_rotation_item(1.0));
  endtask

  // non-unit quaternions, the result scales by |q|^2 and may saturate
  task automatic test_scaled_quaternions(input int count);
    repeat (count) send_item(random_rotation_item(0.05 + $urandom_range(0, 1940) / 1000.0));
  endtask

  task automatic test_back_to_back(input int count);
    repeat (count) send_item(random_rotation_item(1.0));
  endtask

  // any bit pattern on any field; quaternion sometimes shrunk so not all saturate
  task automatic test_raw_patterns(input int count);
    qvr_pkg::item_t it;
    int             sh;
    repeat (count) begin
      it = qvr_pkg::item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom});
      if ($urandom_range(0, 1) == 0) begin
        sh = $urandom_range(1, 12);
        it.quat_i = it.quat_i >>> sh;
        it.quat_j = it.quat_j >>> sh;
        it.quat_k = it.quat_k >>> sh;
        it.quat_w = it.quat_w >>> sh;
      end
      send_item(it);
    end
  endtask

  // result side holds off long enough for the pipeline to fill and stall its input
  task automatic test_backpressure_fill();
    hold_left = 60;
    repeat (30) send_item(random_rotation_item(1.0));
  endtask

  // sender stops until every result is back, then resumes
  task automatic test_pause_until_drained();
    repeat (10) send_item(random_rotation_item(1.0));
    wait_for_results();
    repeat (10) send_item(random_rotation_item(1.0));
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    sender_idles = 1;
    receiver_idles = 1;
    test_unit_rotations(350);
    test_scaled_quaternions(150);
    sender_idles = 0;
    receiver_idles = 0;
    test_back_to_back(60);
    test_backpressure_fill();
    sender_idles = 1;
    receiver_idles = 1;
    test_raw_patterns(150);
    test_pause_until_drained();

    wait_for_results();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/qvr_pkg.sv
sv/qvr_datapath.sv
sv/quaternion_vector_rotate.sv
sv/qvr_checker.sv
test/testbench.sv
